/* design/assert_macros.svh */
// Assertion macros shared by the packetizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition in one cycle that forces another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/pvp_pkg.sv */
// Package with constants and types of the PES video packetizer.
package pvp_pkg;

  // Largest packet in bytes, header included.
  localparam int PacketMax = 2048;
  localparam int PtsW = 33;
  localparam int LenW = 24;
  localparam int MaxResults = 12;
  localparam int CntW = $clog2(MaxResults + 1);
  localparam int IdxW = $clog2(MaxResults);

  // Room for payload once the fixed six header bytes are counted.
  localparam logic [15:0] RoomBase = 16'(PacketMax - 6);

  // Register indexes of the configuration port.
  localparam logic [7:0] RegPts = 8'd0;
  localparam logic [7:0] RegStreamId = 8'd1;

  // Register reset values.
  localparam logic [PtsW-1:0] PtsReset = 33'd1;
  localparam logic [7:0] StreamIdReset = 8'he0;

  // Header byte codes.
  localparam logic [7:0] PrefixZero = 8'h00;
  localparam logic [7:0] PrefixOne = 8'h01;
  localparam logic [7:0] StuffByte = 8'h0f;
  localparam logic [3:0] PtsMarker = 4'h2;
  localparam logic [2:0] ExtPts = 3'd5;
  localparam logic [2:0] ExtStuff = 3'd1;

  // Positions of the data byte in the result run.
  localparam logic [IdxW-1:0] DataPosPts = IdxW'(11);
  localparam logic [IdxW-1:0] DataPosStuff = IdxW'(7);
  localparam logic [IdxW-1:0] DataPosBare = IdxW'(0);

  typedef struct packed {
    logic [7:0] data_byte;
    logic [LenW-1:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic last_in_packet;
    logic last_in_frame;
    logic run_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] reg_index;
    logic [PtsW-1:0] reg_data;
  } cfg_write_t;

endpackage

/* design/pvp_if.sv */
// Valid/ready channel interfaces of the PES video packetizer.
interface pvp_in_if import pvp_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface pvp_out_if import pvp_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface pvp_cfg_if import pvp_pkg::*; ();
  logic valid;
  logic ready;
  cfg_write_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

/* design/pes_video_packetizer.sv */
// Top level of the PES video packetizer: byte stream in, PES packet bytes out.
// The block takes one frame byte per item and emits one output byte per cycle unless the output
// stalls. A payload byte inside a packet adds no header, so such items flow at one per cycle
// unless the output stalls. The first byte of a packet also carries the packet header: 7
// header bytes with a stuffing byte, or 11 with a time stamp, and the input is held off until
// only the last byte of the run remains in the output shift register. A frame length of zero
// while no frame is open drops the byte and emits nothing. Register writes take effect on the
// next packet header; write them only while the block is idle.
`include "assert_macros.svh"
module pes_video_packetizer import pvp_pkg::*; (
  input logic clk,
  input logic rst,
  pvp_in_if.sink in_items,
  pvp_out_if.source out_items,
  pvp_cfg_if.sink cfg
);

  // Configuration registers.
  logic [PtsW-1:0] pts_value;
  logic [7:0] stream_id;

  // Frame and packet tracking.
  logic [LenW-1:0] frame_bytes_left, frame_bytes_left_next;
  logic [15:0] packet_bytes_left, packet_bytes_left_next;
  logic timestamp_sent, timestamp_sent_next;

  // Output shift register and its fill count.
  out_item_t sr [MaxResults];
  out_item_t sr_next [MaxResults];
  logic [CntW-1:0] cnt, cnt_next;

  // Per-item decode.
  logic in_fire, out_fire;
  logic opening, drop, hdr, with_pts;
  logic [LenW-1:0] fbl_cur;
  logic [15:0] pbl_cur, room, payload, plen;
  logic ts_cur;
  logic [2:0] ext;
  logic [7:0] hdr_b [MaxResults-1];
  out_item_t load [MaxResults];
  logic [IdxW-1:0] data_pos;

  assign in_fire = in_items.valid && in_items.ready;
  assign out_fire = out_items.valid && out_items.ready;

  // Take a new item when the shift register empties in this cycle.
  assign in_items.ready = (cnt == '0) || ((cnt == CntW'(1)) && out_items.ready);
  assign out_items.valid = (cnt != '0);
  assign out_items.item = sr[0];
  assign cfg.ready = 1'b1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pts_value <= PtsReset;
      stream_id <= StreamIdReset;
    end else if (cfg.valid) begin
      case (cfg.item.reg_index)
        RegPts: pts_value <= cfg.item.reg_data;
        RegStreamId: stream_id <= cfg.item.reg_data[7:0];
        default: ;
      endcase
    end
  end

  // Frame open, packet split and length decisions for the incoming item.
  always_comb begin
    opening = (frame_bytes_left == '0);
    drop = opening && (in_items.item.frame_length == '0);
    fbl_cur = opening ? in_items.item.frame_length : frame_bytes_left;
    pbl_cur = opening ? 16'd0 : packet_bytes_left;
    ts_cur = opening ? 1'b0 : timestamp_sent;
    hdr = (pbl_cur == 16'd0);
    with_pts = !ts_cur && (pts_value != '0);
    ext = with_pts ? ExtPts : ExtStuff;
    room = RoomBase - 16'(ext);
    payload = (fbl_cur < {{(LenW-16){1'b0}}, room}) ? fbl_cur[15:0] : room;
    plen = payload + 16'(ext);
  end

  // Header bytes in send order, time stamp fields split by marker bits.
  always_comb begin
    hdr_b[0] = PrefixZero;
    hdr_b[1] = PrefixZero;
    hdr_b[2] = PrefixOne;
    hdr_b[3] = stream_id;
    hdr_b[4] = plen[15:8];
    hdr_b[5] = plen[7:0];
    hdr_b[6] = with_pts ? {PtsMarker, pts_value[32:30], 1'b1} : StuffByte;
    hdr_b[7] = pts_value[29:22];
    hdr_b[8] = {pts_value[21:15], 1'b1};
    hdr_b[9] = pts_value[14:7];
    hdr_b[10] = {pts_value[6:0], 1'b1};
  end

  // Result run for the item: header bytes, then the data byte with its flags.
  always_comb begin
    if (!hdr) begin
      data_pos = DataPosBare;
    end else if (with_pts) begin
      data_pos = DataPosPts;
    end else begin
      data_pos = DataPosStuff;
    end
    packet_bytes_left_next = (hdr ? payload : pbl_cur) - 16'd1;
    frame_bytes_left_next = fbl_cur - LenW'(1);
    timestamp_sent_next = hdr || ts_cur;
    for (int i = 0; i < MaxResults; i++) begin
      load[i].out_byte = (i < MaxResults - 1) ? hdr_b[i] : 8'h00;
      load[i].last_in_packet = 1'b0;
      load[i].last_in_frame = 1'b0;
      load[i].run_end = 1'b0;
    end
    load[data_pos].out_byte = in_items.item.data_byte;
    load[data_pos].last_in_packet = (packet_bytes_left_next == 16'd0);
    load[data_pos].last_in_frame = (frame_bytes_left_next == '0);
    load[data_pos].run_end = 1'b1;
  end

  // Shift out one byte per accepted output; load a new run on an accepted item that is not dropped.
  always_comb begin
    sr_next = sr;
    cnt_next = cnt;
    if (out_fire) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        sr_next[i] = sr[i + 1];
      end
      cnt_next = cnt - CntW'(1);
    end
    if (in_fire && !drop) begin
      sr_next = load;
      cnt_next = CntW'(data_pos) + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    sr <= sr_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      frame_bytes_left <= '0;
      packet_bytes_left <= '0;
      timestamp_sent <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (in_fire && !drop) begin
        frame_bytes_left <= frame_bytes_left_next;
        packet_bytes_left <= packet_bytes_left_next;
        timestamp_sent <= timestamp_sent_next;
      end
    end
  end

  // The packet never outlives its frame.
  `ASSERT_ALWAYS(a_pkt_in_frame, (frame_bytes_left != '0) || (packet_bytes_left == '0), "packet open with no frame")
  // An open frame has always begun its first packet.
  `ASSERT_ALWAYS(a_ts_in_frame, (frame_bytes_left == '0) || timestamp_sent, "frame open before first header")
  // A time-stamped header loads a full run of results.
  `ASSERT_NEXT(a_pts_run, in_fire && !drop && hdr && with_pts, cnt == CntW'(MaxResults), "time stamp header run is short")
  // The run end flag only sits on the last byte held.
  `ASSERT_ALWAYS(a_run_end_last, !out_items.valid || !sr[0].run_end || (cnt == CntW'(1)), "run end before last byte")

endmodule
